/* src/wsd_pkg.sv */
package wsd_pkg;

	// Parse phases of the frame header and payload
	typedef enum logic [2:0] {
		PH_HDR1    = 3'd0,
		PH_HDR2    = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	localparam logic [3:0] OPCODE_MASK  = 4'hF;
	localparam logic [3:0] CLOSE_OPCODE = 4'd8;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;

	// Byte counts of the extended length and key fields, modulo 8
	localparam logic [2:0] EXT16_BYTES = 3'd2;
	localparam logic [2:0] EXT64_BYTES = 3'd0;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	// Input register contents
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} in_stage_t;

	// One result item
	typedef struct packed {
		logic       close_request;
		logic       empty_frame;
		logic       end_of_frame;
		logic       final_fragment;
		logic [3:0] frame_opcode;
		logic [7:0] payload_byte;
	} result_t;

endpackage

/* src/wsd_in_stage.sv */
module wsd_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                advance,
	output wsd_pkg::in_stage_t  stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// Take a new byte when the register is empty or being consumed
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign stage.valid   = valid_s1;
	assign stage.rx_byte = byte_s1;

endmodule

/* src/wsd_parser.sv */
module wsd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  wsd_pkg::in_stage_t  stage,
	input  logic                advance,
	output logic                emit,
	output wsd_pkg::result_t    result
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  count_q, count_d, count_inc;
	logic [63:0] remaining_q, remaining_d, remaining_dec;
	logic [31:0] key_q, key_d;
	logic [1:0]  key_pos_q, key_pos_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        fin_q, fin_d;
	logic [7:0]  b;
	logic [7:0]  key_byte;
	logic [2:0]  need;

	assign b             = stage.rx_byte;
	assign count_inc     = count_q + 3'd1;
	assign remaining_dec = remaining_q - 64'd1;
	assign need          = (phase_q == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_BYTES
	                                                      : wsd_pkg::EXT64_BYTES;

	// Select the key byte for the next payload byte, first key byte first
	always_comb begin
		case (key_pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		remaining_d = remaining_q;
		key_d       = key_q;
		key_pos_d   = key_pos_q;
		opcode_d    = opcode_q;
		fin_d       = fin_q;
		emit        = 1'b0;

		result.payload_byte   = 8'd0;
		result.frame_opcode   = opcode_q & wsd_pkg::OPCODE_MASK;
		result.final_fragment = fin_q;
		result.end_of_frame   = 1'b0;
		result.empty_frame    = 1'b0;
		result.close_request  = (opcode_q == wsd_pkg::CLOSE_OPCODE);

		unique case (phase_q)
			wsd_pkg::PH_HDR2: begin
				remaining_d = 64'd0;
				count_d     = 3'd0;
				if (b[6:0] == wsd_pkg::LEN_EXT16) begin
					phase_d = wsd_pkg::PH_EXT16;
				end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
					phase_d = wsd_pkg::PH_EXT64;
				end else begin
					remaining_d = {57'd0, b[6:0]};
					phase_d     = wsd_pkg::PH_KEY;
					key_d       = 32'd0;
					key_pos_d   = 2'd0;
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				remaining_d = {remaining_q[55:0], b};
				count_d     = count_inc;
				if (count_inc == need) begin
					phase_d   = wsd_pkg::PH_KEY;
					count_d   = 3'd0;
					key_d     = 32'd0;
					key_pos_d = 2'd0;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_d   = {key_q[23:0], b};
				count_d = count_inc;
				if (count_inc == wsd_pkg::KEY_BYTES) begin
					count_d   = 3'd0;
					key_pos_d = 2'd0;
					if (remaining_q == 64'd0) begin
						// Zero-length frame: emit the empty marker
						phase_d             = wsd_pkg::PH_HDR1;
						emit                = 1'b1;
						result.end_of_frame = 1'b1;
						result.empty_frame  = 1'b1;
					end else begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				key_pos_d           = key_pos_q + 2'd1;
				remaining_d         = remaining_dec;
				emit                = 1'b1;
				result.payload_byte = b ^ key_byte;
				if (remaining_dec == 64'd0) begin
					phase_d             = wsd_pkg::PH_HDR1;
					result.end_of_frame = 1'b1;
				end
			end
			default: begin
				// First header byte, also taken for any unused phase code
				fin_d    = b[7];
				opcode_d = b[3:0];
				phase_d  = wsd_pkg::PH_HDR2;
			end
		endcase
	end

	// Advance the parse state once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wsd_pkg::PH_HDR1;
			count_q     <= 3'd0;
			remaining_q <= 64'd0;
			key_q       <= 32'd0;
			key_pos_q   <= 2'd0;
			opcode_q    <= 4'd0;
			fin_q       <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			remaining_q <= remaining_d;
			key_q       <= key_d;
			key_pos_q   <= key_pos_d;
			opcode_q    <= opcode_d;
			fin_q       <= fin_d;
		end
	end

endmodule

/* src/wsd_out_stage.sv */
module wsd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  wsd_pkg::result_t  result,
	output logic              space,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic [6:0]        m_tuser
);

	logic             valid_q;
	wsd_pkg::result_t result_q;

	// Register is free when empty or its transaction completes now
	assign space = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = result_q.payload_byte;
	assign m_tlast  = result_q.end_of_frame;
	assign m_tuser  = {result_q.close_request, result_q.empty_frame,
	                   result_q.final_fragment, result_q.frame_opcode};

endmodule

/* src/websocket_frame_deframer_unmask.sv */
// Channel   Dir  Width                  Contents
// s_*       in   tdata 8                rx_byte
// m_*       out  tdata 8, tlast, tuser 7 payload_byte; end_of_frame;
//                                        frame_opcode, final_fragment, empty_frame, close_request
//
// One byte per cycle sustained while m_tready does not stall; a byte's transaction loads the
// input register, and its outcome is loaded into the output register once that has space.
// arst_n clears the parse state to expect a first header byte and empties both registers.
// A stall on m_tready holds the result register; the input register still takes a byte
// while it is empty or the result register is free or being drained in the same cycle.
module websocket_frame_deframer_unmask (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic       m_tlast,
	output logic [6:0] m_tuser    // [3:0] frame_opcode, [4] final_fragment,
	                              // [5] empty_frame, [6] close_request
);

	wsd_pkg::in_stage_t stage;
	wsd_pkg::result_t   result;
	logic               advance;
	logic               emit;
	logic               space;

	// Consume the held byte when the result register can take its outcome
	assign advance = stage.valid && space;

	wsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.stage    (stage)
	);

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.emit    (emit),
		.result  (result)
	);

	wsd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.result   (result),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef ASSERT_OFF
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[5] |-> m_tlast)
		else $error("empty marker without end of frame");

	a_empty_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[5] |-> m_tdata == 8'd0)
		else $error("empty marker carries data");

	a_close_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[6] == (m_tuser[3:0] == wsd_pkg::CLOSE_OPCODE))
		else $error("close flag disagrees with opcode");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");
`endif

endmodule

/* sim/websocket_frame_deframer_unmask_checker.sv */
module websocket_frame_deframer_unmask_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] payload_byte
	input  logic       m_tlast,
	input  logic [6:0] m_tuser,   // [3:0] frame_opcode, [4] final_fragment,
	                              // [5] empty_frame, [6] close_request
	output int         fail_count,
	output int         pending_count
);

	// Frame parser state mirrored from the received byte stream
	wsd_pkg::phase_t frame_phase;
	logic [2:0]  field_count;
	logic [63:0] bytes_left;
	logic [31:0] key_word;
	logic [1:0]  key_index;
	logic [3:0]  frame_op;
	logic        frame_fin;

	wsd_pkg::result_t unmasked_bytes[$];
	int      error_total;

	// Count an error; print only the first few
	task automatic note_error(input string text);
		error_total++;
		if (error_total <= 10) begin
			$display("%0t: %s", $realtime, text);
		end
	endtask

	// Queue one predicted output transaction for the current frame
	task automatic queue_result(input logic [7:0] data, input logic eof, input logic empty);
		wsd_pkg::result_t r;
		r.payload_byte   = data;
		r.frame_opcode   = frame_op & wsd_pkg::OPCODE_MASK;
		r.final_fragment = frame_fin;
		r.end_of_frame   = eof;
		r.empty_frame    = empty;
		r.close_request  = (frame_op == wsd_pkg::CLOSE_OPCODE);
		unmasked_bytes.push_back(r);
	endtask

	task automatic start_key();
		frame_phase = wsd_pkg::PH_KEY;
		field_count = '0;
		key_word    = '0;
		key_index   = '0;
	endtask

	// Advance the parser by one received byte
	task automatic parse_byte(input logic [7:0] rx);
		logic [2:0] need;
		logic [7:0] key_byte;
		case (frame_phase)
			wsd_pkg::PH_HDR2: begin
				bytes_left  = '0;
				field_count = '0;
				if (rx[6:0] == wsd_pkg::LEN_EXT16) begin
					frame_phase = wsd_pkg::PH_EXT16;
				end else if (rx[6:0] == wsd_pkg::LEN_EXT64) begin
					frame_phase = wsd_pkg::PH_EXT64;
				end else begin
					bytes_left = {57'd0, rx[6:0]};
					start_key();
				end
			end
			wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
				need        = (frame_phase == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_BYTES
				                                                 : wsd_pkg::EXT64_BYTES;
				bytes_left  = {bytes_left[55:0], rx};
				field_count = field_count + 3'd1;
				if (field_count == need) begin
					start_key();
				end
			end
			wsd_pkg::PH_KEY: begin
				key_word    = {key_word[23:0], rx};
				field_count = field_count + 3'd1;
				if (field_count == wsd_pkg::KEY_BYTES) begin
					field_count = '0;
					key_index   = '0;
					if (bytes_left == 64'd0) begin
						frame_phase = wsd_pkg::PH_HDR1;
						queue_result(8'h00, 1'b1, 1'b1);
					end else begin
						frame_phase = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				key_byte   = key_word[8 * (3 - int'(key_index)) +: 8];
				key_index  = key_index + 2'd1;
				bytes_left = bytes_left - 64'd1;
				if (bytes_left == 64'd0) begin
					frame_phase = wsd_pkg::PH_HDR1;
				end
				queue_result(rx ^ key_byte, bytes_left == 64'd0, 1'b0);
			end
			default: begin
				// first header byte; RSV bits are dropped
				frame_fin   = rx[7];
				frame_op    = rx[3:0];
				frame_phase = wsd_pkg::PH_HDR2;
			end
		endcase
	endtask

	// Compare each output transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		wsd_pkg::result_t want;
		wsd_pkg::result_t got;
		if (!arst_n) begin
			frame_phase = wsd_pkg::PH_HDR1;
			field_count = '0;
			bytes_left  = '0;
			key_word    = '0;
			key_index   = '0;
			frame_op    = '0;
			frame_fin   = 1'b0;
			unmasked_bytes.delete();
			error_total = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.payload_byte   = m_tdata;
				got.end_of_frame   = m_tlast;
				got.frame_opcode   = m_tuser[3:0];
				got.final_fragment = m_tuser[4];
				got.empty_frame    = m_tuser[5];
				got.close_request  = m_tuser[6];
				if (unmasked_bytes.size() == 0) begin
					note_error($sformatf("unexpected output: data %02h op %h fin %b last %b empty %b close %b",
						got.payload_byte, got.frame_opcode, got.final_fragment,
						got.end_of_frame, got.empty_frame, got.close_request));
				end else begin
					want = unmasked_bytes.pop_front();
					if (got.payload_byte !== want.payload_byte ||
					    got.frame_opcode !== want.frame_opcode ||
					    got.final_fragment !== want.final_fragment ||
					    got.end_of_frame !== want.end_of_frame ||
					    got.empty_frame !== want.empty_frame ||
					    got.close_request !== want.close_request) begin
						note_error($sformatf({"mismatch: expected data %02h op %h fin %b last %b",
							" empty %b close %b, got data %02h op %h fin %b last %b empty %b close %b"},
							want.payload_byte, want.frame_opcode, want.final_fragment,
							want.end_of_frame, want.empty_frame, want.close_request,
							got.payload_byte, got.frame_opcode, got.final_fragment,
							got.end_of_frame, got.empty_frame, got.close_request));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata);
			end
			fail_count    <= error_total;
			pending_count <= unmasked_bytes.size();
		end
	end

endmodule

/* sim/websocket_frame_deframer_unmask_test.sv */
module websocket_frame_deframer_unmask_test;

	localparam int RANDOM_BYTES = 1300;
	localparam int QUIET_TAIL   = 200;
	localparam int STALL_LIMIT  = 1000;

	// Length encodings of the second header byte
	typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tready = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [6:0] m_tuser;

	int fail_count;
	int pending_count;
	bit gaps_on     = 1'b0;
	int bytes_sent  = 0;
	int stall_left  = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	websocket_frame_deframer_unmask u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	websocket_frame_deframer_unmask_checker u_frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Stall the output side in random bursts while gaps are enabled
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Abort when no transaction moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one byte, hold it until accepted, then maybe idle
	task automatic send_byte(input logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Send one frame: header, length, random key, then random payload bytes
	task automatic send_frame(input logic [7:0] head, input logic mask_bit,
	                          input len_form_t form, input logic [63:0] payload_len,
	                          input int payload_count);
		send_byte(head);
		case (form)
			LEN_16: begin
				send_byte({mask_bit, wsd_pkg::LEN_EXT16});
				send_byte(payload_len[15:8]);
				send_byte(payload_len[7:0]);
			end
			LEN_64: begin
				send_byte({mask_bit, wsd_pkg::LEN_EXT64});
				for (int i = 7; i >= 0; i--) begin
					send_byte(payload_len[8 * i +: 8]);
				end
			end
			default: begin
				send_byte({mask_bit, payload_len[6:0]});
			end
		endcase
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		repeat (payload_count) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		len_form_t   form;
		logic [63:0] len;
		int          pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty close frame with mask bit clear and RSV bits set
		send_frame({1'b1, 3'b111, wsd_pkg::CLOSE_OPCODE}, 1'b0, LEN_SHORT, 64'd0, 0);
		// Reserved opcode, all header bits set, 16-bit length below 126
		send_frame(8'hFF, 1'b1, LEN_16, 64'd1, 1);
		// Continuation without FIN, 64-bit length below 126
		send_frame(8'h00, 1'b1, LEN_64, 64'd2, 2);

		// Random frames; the tail runs without gaps
		while (bytes_sent < RANDOM_BYTES) begin
			gaps_on = (bytes_sent < RANDOM_BYTES - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				form = LEN_SHORT;
				len  = 64'($urandom_range(0, 12));
			end else if (pick < 65) begin
				form = LEN_SHORT;
				len  = 64'($urandom_range(0, 125));
			end else if (pick < 82) begin
				form = LEN_16;
				len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 400))
				                                   : 64'($urandom_range(0, 20));
			end else begin
				form = LEN_64;
				len  = 64'($urandom_range(0, 20));
			end
			send_frame({4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))},
				$urandom_range(0, 7) != 0, form, len, int'(len));
		end

		// Huge 64-bit length with the top bit set; stop partway through the payload
		gaps_on = 1'b0;
		send_frame(8'h82, 1'b1, LEN_64, 64'h8000_0000_0000_0005, 12);
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending_count != 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
